### rtl/slfp_pkg.sv
// Shared types and constants for the service-linking field parser.
// Depends on nothing; every other file of the block imports it.
package slfp_pkg;

    // Widths of the key tables.
    localparam int KEY_W   = 16;
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};

    // Default depth of the queue between the front and back ends.
    localparam int SLFP_QUEUE_DEPTH = 4;

    // Input operation codes.
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Record kinds.
    localparam logic [2:0] KIND_HDR_PLAIN = 3'd0;
    localparam logic [2:0] KIND_HDR_LIST  = 3'd1;
    localparam logic [2:0] KIND_ID_ENTRY  = 3'd2;
    localparam logic [2:0] KIND_DEADLINK  = 3'd3;
    localparam logic [2:0] KIND_END       = 3'd4;

    // Link change codes.
    localparam logic [1:0] CHG_NONE  = 2'd0;
    localparam logic [1:0] CHG_ACT   = 2'd1;
    localparam logic [1:0] CHG_DEACT = 2'd2;

    // Id list qualifier codes.
    localparam logic [1:0] IDLQ_DAB  = 2'd0;
    localparam logic [1:0] IDLQ_RDS  = 2'd1;
    localparam logic [1:0] IDLQ_AMFM = 2'd2;
    localparam logic [1:0] IDLQ_DRM  = 2'd3;

    // Identifier types.
    localparam logic [2:0] TYPE_DAB_SID  = 3'd0;
    localparam logic [2:0] TYPE_RDS_PI   = 3'd1;
    localparam logic [2:0] TYPE_AMFM     = 3'd2;
    localparam logic [2:0] TYPE_DRM      = 3'd3;
    localparam logic [2:0] TYPE_INVALID  = 3'd4;
    localparam logic [2:0] TYPE_DATA_SID = 3'd5;

    // Bit positions of the record mask, in the order the records leave.
    localparam int REC_HDR   = 0;
    localparam int REC_CNT   = 1;
    localparam int REC_DEAD  = 2;
    localparam int REC_ENTRY = 3;
    localparam int REC_END   = 4;
    localparam int REC_N     = 5;

    // Parser phase of the front end.
    typedef enum logic [1:0] {
        PH_HDR1,
        PH_HDR2,
        PH_COUNT,
        PH_ENTRY
    } slfp_phase_t;

    // Back end sequencer state.
    typedef enum logic [1:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_LOOK,
        BK_EMIT
    } slfp_bk_state_t;

    // Command word passed from the front end to the back end.
    typedef struct packed {
        logic             do_clear;
        logic             do_hdr;
        logic [REC_N-1:0] rec_mask;
        logic [KEY_W-1:0] key;
        logic             la;
        logic             cn;
        logic [1:0]       q;
        logic             shd;
        logic [3:0]       cnt;
        logic [2:0]       id_type;
        logic [31:0]      id_value;
    } slfp_cmd_t;

    // One result record.
    typedef struct packed {
        logic [2:0]       kind;
        logic [KEY_W-1:0] key;
        logic             la;
        logic [1:0]       chg;
        logic             cev;
        logic [1:0]       q;
        logic             shd;
        logic [3:0]       cnt;
        logic [2:0]       id_type;
        logic [31:0]      id_value;
        logic             complete;
        logic             last;
    } slfp_rec_t;

endpackage

### rtl/service_linking_field_parser.sv
// Top level of the service-linking field parser.
// Depends on slfp_pkg, slfp_front, slfp_queue and slfp_back.
//
// The block takes the data bytes of service-linking groups, one word per byte, and returns
// header, identifier, dead-link and end-of-group records. A front end parses the bytes and
// posts one command per word that has work to do into a small queue; a back end looks the
// header key up in a 64K-entry link-state memory and a 64K-entry seen-key memory and shifts
// the records out through a result register, so a waiting result holds the input off only
// once the queue has filled up.
// Flow: the first header byte and inner identifier bytes post no command to the queue.
// A word that produces records is picked up by the back end from idle; a header then
// goes through a lookup (read, then read-modify-write of the key memories), and the
// records are shifted out one at a time, each waiting while the receiver stalls. After
// reset the block runs a clearing pass over all 65536 addresses of both key memories and
// holds item_stall high meanwhile. A clear word starts the same pass over the link-state
// memory. The seen-key memory is emptied by advancing an 8-bit epoch, and every 255th
// repeated key costs one pass over the epoch tags.
module service_linking_field_parser
    import slfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = SLFP_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    input  logic        change_flag_cn,
    input  logic        other_ensemble,
    input  logic        data_service,
    input  logic        group_last,
    output logic        record_valid,
    input  logic        record_stall,
    output logic [2:0]  record_kind,
    output logic [15:0] linkage_key,
    output logic        link_active,
    output logic [1:0]  link_change,
    output logic        change_event,
    output logic [1:0]  id_qualifier,
    output logic        shd_flag,
    output logic [3:0]  id_count,
    output logic [2:0]  id_type,
    output logic [31:0] id_value,
    output logic        group_complete,
    output logic        last_result
);

    logic      accept;
    logic      push;
    slfp_cmd_t push_cmd;
    logic      q_full;
    logic      pop;
    logic      head_valid;
    slfp_cmd_t head_cmd;
    logic      sweeping;
    slfp_rec_t rec;

    // Words are held off while the queue is full or a memory sweep is in progress.
    assign item_stall = q_full || sweeping;
    assign accept     = item_valid && !item_stall;

    slfp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .operation      (operation),
        .data_byte      (data_byte),
        .change_flag_cn (change_flag_cn),
        .other_ensemble (other_ensemble),
        .data_service   (data_service),
        .group_last     (group_last),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    slfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    slfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .sweeping   (sweeping),
        .rec_valid  (record_valid),
        .rec        (rec),
        .rec_stall  (record_stall)
    );

    assign record_kind    = rec.kind;
    assign linkage_key    = rec.key;
    assign link_active    = rec.la;
    assign link_change    = rec.chg;
    assign change_event   = rec.cev;
    assign id_qualifier   = rec.q;
    assign shd_flag       = rec.shd;
    assign id_count       = rec.cnt;
    assign id_type        = rec.id_type;
    assign id_value       = rec.id_value;
    assign group_complete = rec.complete;
    assign last_result    = rec.last;

endmodule

### rtl/slfp_front.sv
// Front end: byte-level parser of the service-linking field.
// Depends on slfp_pkg; turns accepted words that have work to do into commands for the back end.
module slfp_front
    import slfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic      operation,
    input  logic [7:0] data_byte,
    input  logic      change_flag_cn,
    input  logic      other_ensemble,
    input  logic      data_service,
    input  logic      group_last,
    output logic      push,
    output slfp_cmd_t push_cmd
);

    slfp_phase_t      phase_reg, phase_next;
    logic [7:0]       b0_reg, b0_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             la_reg, la_next;
    logic             ils_reg, ils_next;
    logic             first_reg, first_next;
    logic [1:0]       q_reg, q_next;
    logic             shd_reg, shd_next;
    logic [3:0]       left_reg, left_next;
    logic [3:0]       index_reg, index_next;
    logic [1:0]       pos_reg, pos_next;
    logic [23:0]      shift_reg, shift_next;

    logic [KEY_W-1:0] new_key;
    logic [3:0]       n_ids;
    logic [1:0]       q_in;
    logic             shd_in;
    logic [2:0]       entry_size;
    logic             entry_done;
    logic [2:0]       entry_type;
    logic [31:0]      entry_value;

    always_comb
    begin
        new_key    = {other_ensemble, data_service, b0_reg[5], b0_reg[4], b0_reg[3:0], data_byte};
        n_ids      = data_byte[3:0];
        q_in       = key_reg[14] ? 2'd0 : data_byte[6:5];
        shd_in     = key_reg[14] ? 1'b0 : data_byte[4];
        entry_size = key_reg[14] ? 3'd4 : (ils_reg ? 3'd3 : 3'd2);
        entry_done = ({1'b0, pos_reg} + 3'd1) >= entry_size;

        if (key_reg[14])
        begin
            entry_type = TYPE_DATA_SID;
        end
        else if ((index_reg == 4'd0) && first_reg)
        begin
            entry_type = TYPE_DAB_SID;
        end
        else
        begin
            case (q_reg)
                IDLQ_DAB:  entry_type = TYPE_DAB_SID;
                IDLQ_RDS:  entry_type = TYPE_RDS_PI;
                IDLQ_AMFM: entry_type = TYPE_AMFM;
                default:   entry_type = ils_reg ? TYPE_DRM : TYPE_INVALID;
            endcase
        end

        case (entry_size)
            3'd2:    entry_value = {16'd0, shift_reg[7:0], data_byte};
            3'd3:    entry_value = {8'd0, shift_reg[15:0], data_byte};
            default: entry_value = {shift_reg, data_byte};
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        b0_next    = b0_reg;
        key_next   = key_reg;
        la_next    = la_reg;
        ils_next   = ils_reg;
        first_next = first_reg;
        q_next     = q_reg;
        shd_next   = shd_reg;
        left_next  = left_reg;
        index_next = index_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        push       = 1'b0;
        push_cmd   = '0;

        if (accept && (operation == OP_CLEAR))
        begin
            push_cmd.do_clear = 1'b1;
            push              = 1'b1;
        end
        else if (accept)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    b0_next    = data_byte;
                    phase_next = PH_HDR2;
                end
                PH_HDR2:
                begin
                    push_cmd.do_hdr = 1'b1;
                    push_cmd.key    = new_key;
                    push_cmd.la     = b0_reg[6];
                    push_cmd.cn     = change_flag_cn;
                    key_next        = new_key;
                    la_next         = b0_reg[6];
                    ils_next        = b0_reg[4];
                    first_next      = !other_ensemble && !change_flag_cn;
                    if (b0_reg[7])
                    begin
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        push_cmd.rec_mask[REC_HDR] = 1'b1;
                        phase_next                 = PH_HDR1;
                    end
                end
                PH_COUNT:
                begin
                    push_cmd.rec_mask[REC_CNT] = 1'b1;
                    push_cmd.key = key_reg;
                    push_cmd.la  = la_reg;
                    push_cmd.q   = q_in;
                    push_cmd.shd = shd_in;
                    push_cmd.cnt = n_ids;
                    q_next       = q_in;
                    shd_next     = shd_in;
                    left_next    = n_ids;
                    index_next   = 4'd0;
                    pos_next     = 2'd0;
                    shift_next   = 24'd0;
                    if (n_ids == 4'd0)
                    begin
                        // An empty list with the RDS qualifier marks a dead link, outside data services.
                        if (!key_reg[14] && (q_in == IDLQ_RDS))
                        begin
                            push_cmd.rec_mask[REC_DEAD] = 1'b1;
                        end
                        phase_next = PH_HDR1;
                    end
                    else
                    begin
                        phase_next = PH_ENTRY;
                    end
                end
                PH_ENTRY:
                begin
                    if (entry_done)
                    begin
                        push_cmd.rec_mask[REC_ENTRY] = 1'b1;
                        push_cmd.key      = key_reg;
                        push_cmd.la       = la_reg;
                        push_cmd.q        = q_reg;
                        push_cmd.shd      = shd_reg;
                        push_cmd.cnt      = index_reg + left_reg;
                        push_cmd.id_type  = entry_type;
                        push_cmd.id_value = entry_value;
                        shift_next        = 24'd0;
                        pos_next          = 2'd0;
                        index_next        = index_reg + 4'd1;
                        left_next         = left_reg - 4'd1;
                        if (left_reg == 4'd1)
                        begin
                            phase_next = PH_HDR1;
                        end
                    end
                    else
                    begin
                        shift_next = {shift_reg[15:0], data_byte};
                        pos_next   = pos_reg + 2'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR1;
                end
            endcase

            if (group_last)
            begin
                push_cmd.rec_mask[REC_END] = 1'b1;
                phase_next = PH_HDR1;
                left_next  = 4'd0;
                index_next = 4'd0;
                pos_next   = 2'd0;
                shift_next = 24'd0;
            end

            push = push_cmd.do_hdr || (push_cmd.rec_mask != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR1;
            b0_reg    <= 8'd0;
            key_reg   <= '0;
            la_reg    <= 1'b0;
            ils_reg   <= 1'b0;
            first_reg <= 1'b0;
            q_reg     <= 2'd0;
            shd_reg   <= 1'b0;
            left_reg  <= 4'd0;
            index_reg <= 4'd0;
            pos_reg   <= 2'd0;
            shift_reg <= 24'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            b0_reg    <= b0_next;
            key_reg   <= key_next;
            la_reg    <= la_next;
            ils_reg   <= ils_next;
            first_reg <= first_next;
            q_reg     <= q_next;
            shd_reg   <= shd_next;
            left_reg  <= left_next;
            index_reg <= index_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
        end
    end

endmodule

### rtl/slfp_queue.sv
// Command queue between the front and back ends of the parser.
// Depends on slfp_pkg for the command word type.
module slfp_queue
    import slfp_pkg::*;
#(
    parameter int DEPTH = SLFP_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  slfp_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output slfp_cmd_t head_cmd
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    slfp_cmd_t        store [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + IDX_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + IDX_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/slfp_back.sv
// Back end: key table lookups, record sequencing and the result register.
// Depends on slfp_pkg; owns the link-state memory and the seen-key epoch memory.
module slfp_back
    import slfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  slfp_cmd_t head_cmd,
    output logic      pop,
    output logic      sweeping,
    output logic      rec_valid,
    output slfp_rec_t rec,
    input  logic      rec_stall
);

    localparam logic [KEY_W-1:0] LAST_ADDR = {KEY_W{1'b1}};
    localparam int DEPTH_KEYS = 1 << KEY_W;

    // Link state per key: bit 0 known, bit 1 last link-active bit.
    logic [1:0]         ls_mem   [DEPTH_KEYS];
    // Seen-key epoch tag per key; a key counts as seen when its tag equals the epoch.
    logic [EPOCH_W-1:0] seen_mem [DEPTH_KEYS];

    slfp_bk_state_t     state_reg, state_next;
    slfp_cmd_t          cmd_reg, cmd_next;
    logic [REC_N-1:0]   pend_reg, pend_next;
    logic [1:0]         chg_reg, chg_next;
    logic               accum_reg, accum_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               wrap_reg, wrap_next;
    logic               sweep_ls_reg, sweep_ls_next;
    logic               sweep_seen_reg, sweep_seen_next;
    logic [KEY_W-1:0]   sweep_addr_reg, sweep_addr_next;
    logic               out_valid_reg, out_valid_next;
    slfp_rec_t          out_rec_reg, out_rec_next;
    logic [1:0]         ls_rd_reg;
    logic [EPOCH_W-1:0] seen_rd_reg;

    logic               ls_we;
    logic [1:0]         ls_wdata;
    logic               seen_we;
    logic [EPOCH_W-1:0] seen_wdata;
    logic [KEY_W-1:0]   mem_waddr;
    logic [REC_N-1:0]   sel;
    logic [REC_N-1:0]   pend_rest;
    logic               repeat_hit;
    logic               can_load;
    slfp_rec_t          rec_new;

    assign sweeping  = (state_reg == BK_SWEEP);
    assign rec_valid = out_valid_reg;
    assign rec       = out_rec_reg;

    // The pending record with the lowest mask bit goes first.
    always_comb
    begin
        sel = '0;
        for (int i = 0; i < REC_N; i++)
        begin
            if (pend_reg[i] && (sel == '0))
            begin
                sel[i] = 1'b1;
            end
        end
        pend_rest = pend_reg & ~sel;
    end

    always_comb
    begin
        rec_new      = '0;
        rec_new.last = (pend_rest == '0);
        if (sel[REC_HDR])
        begin
            rec_new.kind = KIND_HDR_PLAIN;
            rec_new.key  = cmd_reg.key;
            rec_new.la   = cmd_reg.la;
            rec_new.chg  = chg_reg;
            rec_new.cev  = !cmd_reg.cn;
        end
        else if (sel[REC_CNT])
        begin
            rec_new.kind = KIND_HDR_LIST;
            rec_new.key  = cmd_reg.key;
            rec_new.la   = cmd_reg.la;
            rec_new.chg  = chg_reg;
            rec_new.q    = cmd_reg.q;
            rec_new.shd  = cmd_reg.shd;
            rec_new.cnt  = cmd_reg.cnt;
        end
        else if (sel[REC_DEAD])
        begin
            rec_new.kind = KIND_DEADLINK;
            rec_new.key  = cmd_reg.key;
            rec_new.la   = cmd_reg.la;
            rec_new.q    = cmd_reg.q;
            rec_new.shd  = cmd_reg.shd;
            rec_new.cnt  = cmd_reg.cnt;
        end
        else if (sel[REC_ENTRY])
        begin
            rec_new.kind     = KIND_ID_ENTRY;
            rec_new.key      = cmd_reg.key;
            rec_new.la       = cmd_reg.la;
            rec_new.q        = cmd_reg.q;
            rec_new.shd      = cmd_reg.shd;
            rec_new.cnt      = cmd_reg.cnt;
            rec_new.id_type  = cmd_reg.id_type;
            rec_new.id_value = cmd_reg.id_value;
        end
        else
        begin
            rec_new.kind     = KIND_END;
            rec_new.complete = accum_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        pend_next       = pend_reg;
        chg_next        = chg_reg;
        accum_next      = accum_reg;
        epoch_next      = epoch_reg;
        wrap_next       = wrap_reg;
        sweep_ls_next   = sweep_ls_reg;
        sweep_seen_next = sweep_seen_reg;
        sweep_addr_next = sweep_addr_reg;
        out_valid_next  = out_valid_reg && rec_stall;
        out_rec_next    = out_rec_reg;
        pop             = 1'b0;
        ls_we           = 1'b0;
        ls_wdata        = 2'b00;
        seen_we         = 1'b0;
        seen_wdata      = '0;
        mem_waddr       = sweep_addr_reg;
        can_load        = !out_valid_reg || !rec_stall;
        repeat_hit      = (seen_rd_reg == epoch_reg);

        case (state_reg)
            BK_SWEEP:
            begin
                ls_we           = sweep_ls_reg;
                seen_we         = sweep_seen_reg;
                sweep_addr_next = sweep_addr_reg + KEY_W'(1);
                if (sweep_addr_reg == LAST_ADDR)
                begin
                    sweep_ls_next   = 1'b0;
                    sweep_seen_next = 1'b0;
                    state_next      = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (wrap_reg)
                begin
                    // Epoch counter ran out: wipe the tags and start over.
                    wrap_next       = 1'b0;
                    epoch_next      = EPOCH_FIRST;
                    sweep_seen_next = 1'b1;
                    sweep_addr_next = '0;
                    state_next      = BK_SWEEP;
                end
                else if (head_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head_cmd;
                    if (head_cmd.do_clear)
                    begin
                        sweep_ls_next   = 1'b1;
                        sweep_addr_next = '0;
                        state_next      = BK_SWEEP;
                    end
                    else if (head_cmd.do_hdr)
                    begin
                        state_next = BK_LOOK;
                    end
                    else
                    begin
                        pend_next  = head_cmd.rec_mask;
                        state_next = BK_EMIT;
                    end
                end
            end
            BK_LOOK:
            begin
                mem_waddr = cmd_reg.key;
                ls_we     = 1'b1;
                ls_wdata  = {cmd_reg.la, 1'b1};
                if (ls_rd_reg[0] && (ls_rd_reg[1] != cmd_reg.la))
                begin
                    chg_next = cmd_reg.la ? CHG_ACT : CHG_DEACT;
                end
                else
                begin
                    chg_next = CHG_NONE;
                end
                if (repeat_hit)
                begin
                    accum_next = 1'b1;
                    if (epoch_reg == EPOCH_MAX)
                    begin
                        wrap_next = 1'b1;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + EPOCH_W'(1);
                    end
                end
                else
                begin
                    seen_we    = 1'b1;
                    seen_wdata = epoch_reg;
                end
                pend_next  = cmd_reg.rec_mask;
                state_next = (cmd_reg.rec_mask != '0) ? BK_EMIT : BK_IDLE;
            end
            BK_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_rec_next   = rec_new;
                    pend_next      = pend_rest;
                    if (sel[REC_END])
                    begin
                        accum_next = 1'b0;
                    end
                    if (pend_rest == '0)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ls_we)
        begin
            ls_mem[mem_waddr] <= ls_wdata;
        end
        ls_rd_reg <= ls_mem[head_cmd.key];
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[mem_waddr] <= seen_wdata;
        end
        seen_rd_reg <= seen_mem[head_cmd.key];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        out_rec_reg <= out_rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_SWEEP;
            pend_reg       <= '0;
            chg_reg        <= CHG_NONE;
            accum_reg      <= 1'b0;
            epoch_reg      <= EPOCH_FIRST;
            wrap_reg       <= 1'b0;
            sweep_ls_reg   <= 1'b1;
            sweep_seen_reg <= 1'b1;
            sweep_addr_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            chg_reg        <= chg_next;
            accum_reg      <= accum_next;
            epoch_reg      <= epoch_next;
            wrap_reg       <= wrap_next;
            sweep_ls_reg   <= sweep_ls_next;
            sweep_seen_reg <= sweep_seen_next;
            sweep_addr_reg <= sweep_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // No record may be left pending once the sequencer is back to idle.
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_IDLE) |-> (pend_reg == '0))
        else $error("records pending while back end idle");

    // Epoch zero is reserved for swept tags and must never be current.
    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("seen-key epoch is zero");

    // The queue is not drained while a memory sweep is running.
    a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SWEEP) |-> !pop)
        else $error("command popped during sweep");

    // A table lookup always follows the cycle that issued its read.
    a_look_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_LOOK) |-> ($past(state_reg) == BK_IDLE))
        else $error("lookup without read cycle");
`endif

endmodule

### verif/slfp_record_check.sv
// Record checker for the service-linking field parser: watches both channels, predicts
// the records of every accepted word and compares them with what the block returns.
// Depends on slfp_pkg for the record layout, record kinds, identifier types and phases.
module slfp_record_check
    import slfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    input  logic        change_flag_cn,
    input  logic        other_ensemble,
    input  logic        data_service,
    input  logic        group_last,
    input  logic        record_valid,
    input  logic        record_stall,
    input  logic [2:0]  record_kind,
    input  logic [15:0] linkage_key,
    input  logic        link_active,
    input  logic [1:0]  link_change,
    input  logic        change_event,
    input  logic [1:0]  id_qualifier,
    input  logic        shd_flag,
    input  logic [3:0]  id_count,
    input  logic [2:0]  id_type,
    input  logic [31:0] id_value,
    input  logic        group_complete,
    input  logic        last_result,
    output int          failures,
    output int          pending
);

    // Records still owed by the block, oldest first.
    slfp_rec_t expected_recs[$];

    // Both key tables are emptied by bumping a generation number: an entry counts only
    // when its stored generation matches the current one.
    bit          link_la     [65536];
    int unsigned link_gen_of [65536];
    int unsigned seen_gen_of [65536];
    int unsigned link_gen;
    int unsigned seen_gen;

    // Parser state.
    slfp_phase_t phase;
    logic [7:0]  hdr_byte0;
    logic [15:0] held_key;
    logic        held_la;
    logic [1:0]  held_chg;
    logic        held_ils;
    logic        held_first_dab;
    logic [1:0]  held_q;
    logic        held_shd;
    logic [3:0]  ids_left;
    logic [3:0]  id_idx;
    int          byte_pos;
    logic [31:0] id_shift;
    logic        repeat_in_group;

    task automatic post(input logic [2:0] kind, input logic [15:0] key, input logic la,
                        input logic [1:0] chg, input logic cev, input logic [1:0] q,
                        input logic shd, input logic [3:0] cnt, input logic [2:0] typ,
                        input logic [31:0] val, input logic complete);
        slfp_rec_t r;
        r.kind     = kind;
        r.key      = key;
        r.la       = la;
        r.chg      = chg;
        r.cev      = cev;
        r.q        = q;
        r.shd      = shd;
        r.cnt      = cnt;
        r.id_type  = typ;
        r.id_value = val;
        r.complete = complete;
        r.last     = 1'b0;
        expected_recs.push_back(r);
    endtask

    task automatic predict_records(input logic op, input logic [7:0] b, input logic cn,
                                   input logic oe, input logic pd, input logic grp_last);
        logic [15:0] key;
        logic        la_bit;
        logic [1:0]  chg;
        logic [1:0]  q_now;
        logic        shd_now;
        logic [3:0]  n_ids;
        int          id_bytes;
        logic [2:0]  typ;
        logic [31:0] val;
        int          first_new;
        slfp_rec_t   r;
        first_new = expected_recs.size();
        // A clear word only forgets the link-active bits; parsing is untouched.
        if (op == OP_CLEAR) begin
            link_gen++;
            return;
        end
        case (phase)
            PH_HDR1:
            begin
                hdr_byte0 = b;
                phase = PH_HDR2;
            end
            PH_HDR2:
            begin
                la_bit = hdr_byte0[6];
                key = {oe, pd, hdr_byte0[5], hdr_byte0[4], hdr_byte0[3:0], b};
                // A repeated key empties the seen map and marks the group complete.
                if (seen_gen_of[key] == seen_gen) begin
                    seen_gen++;
                    repeat_in_group = 1'b1;
                end
                else begin
                    seen_gen_of[key] = seen_gen;
                end
                chg = CHG_NONE;
                if (link_gen_of[key] == link_gen && link_la[key] != la_bit)
                    chg = la_bit ? CHG_ACT : CHG_DEACT;
                link_gen_of[key] = link_gen;
                link_la[key] = la_bit;
                held_key = key;
                held_la = la_bit;
                held_chg = chg;
                held_ils = hdr_byte0[4];
                held_first_dab = !oe && !cn;
                if (!hdr_byte0[7]) begin
                    post(KIND_HDR_PLAIN, key, la_bit, chg, !cn, '0, 1'b0, '0, '0, '0, 1'b0);
                    phase = PH_HDR1;
                end
                else begin
                    phase = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                n_ids = b[3:0];
                q_now = held_key[14] ? IDLQ_DAB : b[6:5];
                shd_now = held_key[14] ? 1'b0 : b[4];
                post(KIND_HDR_LIST, held_key, held_la, held_chg, 1'b0, q_now, shd_now, n_ids,
                     '0, '0, 1'b0);
                held_q = q_now;
                held_shd = shd_now;
                ids_left = n_ids;
                id_idx = '0;
                byte_pos = 0;
                id_shift = '0;
                if (n_ids == 4'd0) begin
                    if (!held_key[14] && q_now == IDLQ_RDS)
                        post(KIND_DEADLINK, held_key, held_la, CHG_NONE, 1'b0, q_now, shd_now,
                             '0, '0, '0, 1'b0);
                    phase = PH_HDR1;
                end
                else begin
                    phase = PH_ENTRY;
                end
            end
            default:
            begin
                id_bytes = held_key[14] ? 4 : (held_ils ? 3 : 2);
                id_shift = {id_shift[23:0], b};
                if (byte_pos + 1 >= id_bytes) begin
                    if (held_key[14])
                        typ = TYPE_DATA_SID;
                    else if ((id_idx == 4'd0 && held_first_dab) || held_q == IDLQ_DAB)
                        typ = TYPE_DAB_SID;
                    else if (held_q == IDLQ_RDS)
                        typ = TYPE_RDS_PI;
                    else if (held_q == IDLQ_AMFM)
                        typ = TYPE_AMFM;
                    else
                        typ = held_ils ? TYPE_DRM : TYPE_INVALID;
                    val = id_shift;
                    if (id_bytes == 2)
                        val[31:16] = '0;
                    else if (id_bytes == 3)
                        val[31:24] = '0;
                    post(KIND_ID_ENTRY, held_key, held_la, CHG_NONE, 1'b0, held_q, held_shd,
                         4'(id_idx + ids_left), typ, val, 1'b0);
                    id_shift = '0;
                    byte_pos = 0;
                    id_idx = id_idx + 4'd1;
                    ids_left = ids_left - 4'd1;
                    if (ids_left == 4'd0)
                        phase = PH_HDR1;
                end
                else begin
                    byte_pos = byte_pos + 1;
                end
            end
        endcase
        // The end of a group drops whatever was cut short.
        if (grp_last) begin
            post(KIND_END, '0, 1'b0, CHG_NONE, 1'b0, '0, 1'b0, '0, '0, '0, repeat_in_group);
            repeat_in_group = 1'b0;
            phase = PH_HDR1;
            ids_left = '0;
            id_idx = '0;
            byte_pos = 0;
            id_shift = '0;
        end
        if (expected_recs.size() > first_new) begin
            r = expected_recs.pop_back();
            r.last = 1'b1;
            expected_recs.push_back(r);
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        slfp_rec_t want;
        if (!rst_n) begin
            expected_recs.delete();
            link_gen++;
            seen_gen++;
            phase = PH_HDR1;
            hdr_byte0 = '0;
            held_key = '0;
            held_la = 1'b0;
            held_chg = CHG_NONE;
            held_ils = 1'b0;
            held_first_dab = 1'b0;
            held_q = IDLQ_DAB;
            held_shd = 1'b0;
            ids_left = '0;
            id_idx = '0;
            byte_pos = 0;
            id_shift = '0;
            repeat_in_group = 1'b0;
            failures = 0;
        end
        else begin
            if (item_valid && !item_stall)
                predict_records(operation, data_byte, change_flag_cn, other_ensemble,
                                data_service, group_last);
            if (record_valid && !record_stall) begin
                if (expected_recs.size() == 0) begin
                    $error("record of kind %0d arrived with none expected", record_kind);
                    failures++;
                end
                else begin
                    want = expected_recs.pop_front();
                    check_field("record_kind", 32'(want.kind), 32'(record_kind));
                    check_field("linkage_key", 32'(want.key), 32'(linkage_key));
                    check_field("link_active", 32'(want.la), 32'(link_active));
                    check_field("link_change", 32'(want.chg), 32'(link_change));
                    check_field("change_event", 32'(want.cev), 32'(change_event));
                    check_field("id_qualifier", 32'(want.q), 32'(id_qualifier));
                    check_field("shd_flag", 32'(want.shd), 32'(shd_flag));
                    check_field("id_count", 32'(want.cnt), 32'(id_count));
                    check_field("id_type", 32'(want.id_type), 32'(id_type));
                    check_field("id_value", want.id_value, id_value);
                    check_field("group_complete", 32'(want.complete), 32'(group_complete));
                    check_field("last_result", 32'(want.last), 32'(last_result));
                end
            end
        end
        pending = expected_recs.size();
    end

endmodule

### verif/service_linking_field_parser_tb.sv
// Testbench top for the service-linking field parser: drives directed and random groups
// of linking bytes, stalls the record side at random and gives the verdict.
// Depends on slfp_pkg, the block itself and slfp_record_check.
module service_linking_field_parser_tb
    import slfp_pkg::*;
;

    // Words sent in the random part, and how long the receiver holds off once so that
    // the block's internal queue fills and it has to stall the input.
    localparam int RANDOM_WORDS   = 500;
    localparam int LONG_HOLD      = 400;
    // Longest stretch with no word moving on either side. A clearing pass covers all 65536
    // addresses of a key memory; two passes may follow each other.
    localparam int WATCHDOG_LIMIT = 600000;
    localparam int DRAIN_CYCLES   = 64;

    typedef struct packed {
        logic       op;
        logic [7:0] b;
        logic       cn;
        logic       oe;
        logic       pd;
        logic       last;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        operation = OP_DATA;
    logic [7:0]  data_byte = '0;
    logic        change_flag_cn = 1'b0;
    logic        other_ensemble = 1'b0;
    logic        data_service = 1'b0;
    logic        group_last = 1'b0;
    logic        record_valid;
    logic        record_stall = 1'b0;
    logic [2:0]  record_kind;
    logic [15:0] linkage_key;
    logic        link_active;
    logic [1:0]  link_change;
    logic        change_event;
    logic [1:0]  id_qualifier;
    logic        shd_flag;
    logic [3:0]  id_count;
    logic [2:0]  id_type;
    logic [31:0] id_value;
    logic        group_complete;
    logic        last_result;

    int failures;
    int pending;

    // Words of the group being built, with the group's C/N, OE and P/D bits.
    word_t group_q[$];
    logic  grp_cn;
    logic  grp_oe;
    logic  grp_pd;

    // Idling control: each side has a quiet mode in which it never waits, and the
    // sender runs back to back for a while when the receiver holds off.
    bit send_quiet = 1'b0;
    bit take_quiet = 1'b0;
    int burst_left = 0;
    bit long_hold_req = 1'b0;
    int words_sent = 0;
    int idle_cycles = 0;

    always #2 clk = ~clk;

    service_linking_field_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .operation      (operation),
        .data_byte      (data_byte),
        .change_flag_cn (change_flag_cn),
        .other_ensemble (other_ensemble),
        .data_service   (data_service),
        .group_last     (group_last),
        .record_valid   (record_valid),
        .record_stall   (record_stall),
        .record_kind    (record_kind),
        .linkage_key    (linkage_key),
        .link_active    (link_active),
        .link_change    (link_change),
        .change_event   (change_event),
        .id_qualifier   (id_qualifier),
        .shd_flag       (shd_flag),
        .id_count       (id_count),
        .id_type        (id_type),
        .id_value       (id_value),
        .group_complete (group_complete),
        .last_result    (last_result)
    );

    slfp_record_check record_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .operation      (operation),
        .data_byte      (data_byte),
        .change_flag_cn (change_flag_cn),
        .other_ensemble (other_ensemble),
        .data_service   (data_service),
        .group_last     (group_last),
        .record_valid   (record_valid),
        .record_stall   (record_stall),
        .record_kind    (record_kind),
        .linkage_key    (linkage_key),
        .link_active    (link_active),
        .link_change    (link_change),
        .change_event   (change_event),
        .id_qualifier   (id_qualifier),
        .shd_flag       (shd_flag),
        .id_count       (id_count),
        .id_type        (id_type),
        .id_value       (id_value),
        .group_complete (group_complete),
        .last_result    (last_result),
        .failures       (failures),
        .pending        (pending)
    );

    // Offers one word and returns at the edge where it is taken. It is always called
    // right after a rising edge, so every drive below lands on a clock edge. When the
    // gap is zero, valid simply stays high for the next word.
    task automatic send_word(input word_t w);
        int gap;
        if ($urandom_range(0, 15) == 0)
            send_quiet = !send_quiet;
        gap = (send_quiet || burst_left > 0) ? 0 : $urandom_range(0, 13);
        if (burst_left > 0)
            burst_left--;
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid     <= 1'b1;
        operation      <= w.op;
        data_byte      <= w.b;
        change_flag_cn <= w.cn;
        other_ensemble <= w.oe;
        data_service   <= w.pd;
        group_last     <= w.last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // Appends one data byte of the current group.
    task automatic put(input logic [7:0] b);
        word_t w;
        w.op   = OP_DATA;
        w.b    = b;
        w.cn   = grp_cn;
        w.oe   = grp_oe;
        w.pd   = grp_pd;
        w.last = 1'b0;
        group_q.push_back(w);
    endtask

    // Flags the final byte of the group and sends the whole group.
    task automatic send_group();
        word_t w;
        w = group_q.pop_back();
        w.last = 1'b1;
        group_q.push_back(w);
        while (group_q.size() > 0)
            send_word(group_q.pop_front());
    endtask

    // A clear word; its other bits are don't-cares to the block and are exercised too.
    task automatic send_clear(input logic [7:0] b, input logic flag);
        word_t w;
        w.op   = OP_CLEAR;
        w.b    = b;
        w.cn   = flag;
        w.oe   = flag;
        w.pd   = flag;
        w.last = flag;
        send_word(w);
    endtask

    // One random group. Most groups are well-formed runs of linking headers with
    // random lists; keys come mostly from a small pool so that they repeat and flip
    // their link-active bit. Some groups are plain noise and some are cut short.
    task automatic build_random_group();
        int          n_hdr;
        int          n_noise;
        int          id_bytes;
        int          keep;
        logic        list_bit;
        logic        ils_bit;
        logic [3:0]  nib;
        logic [7:0]  b1;
        logic [3:0]  n_ids;
        logic [1:0]  q;
        word_t       w;
        grp_cn = 1'($urandom_range(0, 1));
        grp_oe = 1'($urandom_range(0, 1));
        grp_pd = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) begin
            n_noise = $urandom_range(1, 6);
            repeat (n_noise)
                put(8'($urandom_range(0, 255)));
        end
        else begin
            n_hdr = $urandom_range(1, 4);
            repeat (n_hdr) begin
                list_bit = 1'($urandom_range(0, 1));
                ils_bit = 1'($urandom_range(0, 1));
                nib = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, 1));
                b1 = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 3));
                put({list_bit, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ils_bit,
                     nib});
                put(b1);
                if (list_bit) begin
                    n_ids = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                        : 4'($urandom_range(0, 3));
                    q = 2'($urandom_range(0, 3));
                    put({1'($urandom_range(0, 1)), q, 1'($urandom_range(0, 1)), n_ids});
                    id_bytes = grp_pd ? 4 : (ils_bit ? 3 : 2);
                    repeat (int'(n_ids) * id_bytes)
                        put(8'($urandom_range(0, 255)));
                end
            end
        end
        // Cut the group short now and then, which truncates whatever is in flight.
        if ($urandom_range(0, 7) == 0 && group_q.size() > 1) begin
            keep = $urandom_range(1, group_q.size() - 1);
            while (group_q.size() > keep)
                w = group_q.pop_back();
        end
    endtask

    // Receiver: waits a random number of cycles before each record, and once holds
    // off for a long stretch when the stimulus asks for it.
    initial begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                take_quiet = !take_quiet;
            if (long_hold_req) begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else begin
                hold = take_quiet ? 0 : $urandom_range(0, 13);
            end
            if (hold > 0) begin
                record_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            record_stall <= 1'b0;
            @(posedge clk);
            while (!record_valid)
                @(posedge clk);
        end
    end

    // Watchdog: a run in which no word moves on either side for too long is hung.
    always @(posedge clk) begin
        if (!rst_n || (item_valid && !item_stall) || (record_valid && !record_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("service_linking_field_parser_tb failed");
            $finish;
        end
    end

    initial begin
        int  start;
        int  clears_left;
        bit  pressed;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (rst_n);
        @(posedge clk);

        // Directed part. The first group has C/N and OE clear, so the first-entry rule
        // applies. A plain header is seen first with the link active, then the same key
        // comes back inactive: that reports a deactivation and a repeated key, so the
        // group's end record carries the complete flag. An international list follows
        // with qualifier RDS and Shd set; its first entry is typed DAB SId by the
        // first-entry rule and its second RDS PI.
        grp_cn = 1'b0;
        grp_oe = 1'b0;
        grp_pd = 1'b0;
        put(8'h4F);
        put(8'hFF);
        put(8'h0F);
        put(8'hFF);
        put(8'hF0);
        put(8'h00);
        put(8'h32);
        put(8'h00);
        put(8'h00);
        put(8'h00);
        put(8'hE0);
        put(8'h12);
        put(8'h34);
        send_group();

        // Second group, other ensemble with C/N set: a national list with qualifier 3
        // gives an invalid identifier, then a dead link (no ids, qualifier RDS) closes
        // the group, so its last byte yields three records at once.
        grp_cn = 1'b1;
        grp_oe = 1'b1;
        grp_pd = 1'b0;
        put(8'h80);
        put(8'h12);
        put(8'h71);
        put(8'hFF);
        put(8'hFF);
        put(8'hC5);
        put(8'h34);
        put(8'h20);
        send_group();

        // Forget every link-active bit.
        send_clear(8'hFF, 1'b1);

        // A data-service group: qualifier and Shd bits of the count byte are masked,
        // and the four-byte identifier is cut off by the end of the group.
        grp_cn = 1'b0;
        grp_oe = 1'b1;
        grp_pd = 1'b1;
        put(8'hB0);
        put(8'hAB);
        put(8'hF1);
        put(8'hDE);
        put(8'hAD);
        put(8'hBE);
        send_group();

        // Random part, with a couple of clear words sprinkled between groups and one
        // long hold-off on the record side while words keep coming back to back.
        start = words_sent;
        clears_left = 2;
        pressed = 1'b0;
        while (words_sent - start < RANDOM_WORDS) begin
            if (clears_left > 0 && $urandom_range(0, 49) == 0) begin
                send_clear(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                clears_left--;
            end
            if (!pressed && words_sent - start >= RANDOM_WORDS / 3) begin
                long_hold_req = 1'b1;
                burst_left = 60;
                pressed = 1'b1;
            end
            build_random_group();
            send_group();
        end
        item_valid <= 1'b0;

        // Drain: wait until the last prediction is in and every record has come, then a
        // little longer to catch anything extra.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("service_linking_field_parser_tb passed");
        else
            $display("service_linking_field_parser_tb failed");
        $finish;
    end

endmodule
